### hdl/lowest_free_id_pool_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lowest free ID pool allocator
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LOWEST_FREE_ID_POOL_ALLOCATOR_ASSERT_SVH
`define LOWEST_FREE_ID_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication
`define LFID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LFID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/lfid_pkg.sv
// ----------------------------------------------------------------------------
// lfid_pkg
// Shared types, codes and defaults of the lowest free ID pool allocator.
// ----------------------------------------------------------------------------
package lfid_pkg;

  // Default configuration
  localparam int NUM_POOLS_DEF = 8;
  localparam int MAX_IDS_DEF   = 256;
  localparam int ID_WIDTH_DEF  = 16;

  // Fixed field widths
  localparam int CMD_W  = 2;
  localparam int TAG_W  = 3;
  localparam int WORD_W = 64;
  localparam int BIT_W  = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC      = 2'd0,
    CMD_RELEASE    = 2'd1,
    CMD_RESET_POOL = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EXHAUSTED    = 3'd1,
    ST_UNKNOWN      = 3'd2,
    ST_ALREADY_FREE = 3'd3,
    ST_RANGE        = 3'd4
  } status_t;

  // Encode a one-hot 64-bit word into its bit index
  function automatic logic [BIT_W-1:0] onehot_idx(input logic [WORD_W-1:0] oh);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (oh[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### hdl/lfid_ram.sv
// ----------------------------------------------------------------------------
// lfid_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lfid_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/lowest_free_id_pool_allocator.sv
// ----------------------------------------------------------------------------
// lowest_free_id_pool_allocator
// Per-pool free bitmaps in RAM; allocate hands out the lowest free ID.
// ----------------------------------------------------------------------------
// Requests are taken one at a time on start while busy is low; each request
// gives exactly one result on out_valid for a single cycle, and the receiver
// cannot stall it. The next request may be issued in the strobe cycle. With
// W = ceil(MAX_IDS/64) bitmap words per pool (W = 4 at the defaults): reset
// pool, unknown pool and the unused command answer from decode alone; release
// reads the range, then does a read-modify-write of one bitmap word, or stops
// after the range read when rejected on the range; allocate into a pool that
// is not live writes all W bitmap words, one word per cycle; allocate into a
// live pool reads bitmap words in turn until a free bit is found. The bitmap
// RAM has a single, registered read port. Requests run strictly one after
// another, so every write-back lands before the next read. Pool ranges and
// bitmaps need no clearing after reset: live bits live in flip-flops and gate
// every read.
// ----------------------------------------------------------------------------
module lowest_free_id_pool_allocator #(
  parameter int NUM_POOLS = lfid_pkg::NUM_POOLS_DEF,
  parameter int MAX_IDS   = lfid_pkg::MAX_IDS_DEF,
  parameter int ID_WIDTH  = lfid_pkg::ID_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [lfid_pkg::CMD_W-1:0] in_command,
  input  logic [lfid_pkg::TAG_W-1:0] in_pool,
  input  logic [ID_WIDTH-1:0]        in_id_in,
  input  logic [ID_WIDTH-1:0]        in_min_id,
  input  logic [ID_WIDTH-1:0]        in_max_id,
  output logic                       out_valid,
  output logic [ID_WIDTH-1:0]        out_id_out,
  output lfid_pkg::status_t          out_status
);

  import lfid_pkg::*;

  localparam int POOL_WORDS = (MAX_IDS + WORD_W - 1) / WORD_W;
  localparam int WIDX_W     = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
  localparam int WDEPTH     = NUM_POOLS * POOL_WORDS;
  localparam int WA_W       = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int PIDX_W     = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int CNT_A      = ID_WIDTH + 1;
  localparam int CNT_B      = $clog2(POOL_WORDS * WORD_W + 1);
  localparam int CNT_W      = (CNT_A > CNT_B) ? CNT_A : CNT_B;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_FILL,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_REL_CHK,
    S_REL_RD,
    S_REL_UPD
  } state_t;

  state_t                state_r, state_nxt;
  logic [CMD_W-1:0]      cmd_r;
  logic [TAG_W-1:0]      pool_r;
  logic [ID_WIDTH-1:0]   id_r, min_r, max_r;
  logic [CMD_W-1:0]      cmd_nxt;
  logic [TAG_W-1:0]      pool_nxt;
  logic [ID_WIDTH-1:0]   id_nxt, min_nxt, max_nxt;
  logic [WIDX_W-1:0]     widx_r, widx_nxt;
  logic [BIT_W-1:0]      bit_r, bit_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [NUM_POOLS-1:0]  live_r, live_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ID_WIDTH-1:0]   out_id_r, out_id_nxt;
  status_t               out_status_r, out_status_nxt;

  logic [PIDX_W-1:0]     tag_idx;
  logic                  tag_unknown;
  logic [WA_W-1:0]       word_addr;
  logic                  word_we;
  logic [WORD_W-1:0]     word_wdata, word_rdata;
  logic                  rng_we;
  logic [2*ID_WIDTH-1:0] rng_wdata, rng_rdata;
  logic [ID_WIDTH-1:0]   rng_low, rng_high;

  logic [WORD_W-1:0]     scan_iso;
  logic [BIT_W-1:0]      scan_bit;
  logic [ID_WIDTH-1:0]   alloc_id;
  logic [CNT_W-1:0]      span, base, top, rem;
  logic [WORD_W-1:0]     fill_word;
  logic [ID_WIDTH-1:0]   fill_high;
  logic [ID_WIDTH-1:0]   rel_off;
  logic                  last_word;

  // Pool index and word address
  assign tag_idx     = PIDX_W'(pool_r);
  assign tag_unknown = int'(pool_r) >= NUM_POOLS;
  assign word_addr   = WA_W'(int'(tag_idx) * POOL_WORDS + int'(widx_r));
  assign last_word   = widx_r == WIDX_W'(POOL_WORDS - 1);
  assign rng_low     = rng_rdata[ID_WIDTH-1:0];
  assign rng_high    = rng_rdata[2*ID_WIDTH-1:ID_WIDTH];

  // Lowest free bit of the word under scan
  assign scan_iso = word_rdata & (~word_rdata + WORD_W'(1));
  assign scan_bit = onehot_idx(scan_iso);
  assign alloc_id = rng_low + ID_WIDTH'({widx_r, scan_bit});

  // Range span, clamped later to the pool size
  assign span = CNT_W'(max_r) - CNT_W'(min_r) + CNT_W'(1);

  // Fill pattern of the current bitmap word
  assign base = CNT_W'({widx_r, {BIT_W{1'b0}}});
  assign top  = base + CNT_W'(WORD_W);
  assign rem  = count_r - base;
  always_comb begin
    if (count_r >= top) begin
      fill_word = '1;
    end else if (count_r > base) begin
      fill_word = ~({WORD_W{1'b1}} << rem[BIT_W-1:0]);
    end else begin
      fill_word = '0;
    end
  end
  assign fill_high = (count_r == '0) ? max_r
                   : ID_WIDTH'(CNT_W'(min_r) + count_r - CNT_W'(1));

  assign rel_off = id_r - rng_low;

  // Sequencer next-state and datapath
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    pool_nxt       = pool_r;
    id_nxt         = id_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    widx_nxt       = widx_r;
    bit_nxt        = bit_r;
    count_nxt      = count_r;
    live_nxt       = live_r;
    out_valid_nxt  = 1'b0;
    out_id_nxt     = out_id_r;
    out_status_nxt = out_status_r;
    word_we        = 1'b0;
    word_wdata     = fill_word;
    rng_we         = 1'b0;
    rng_wdata      = {fill_high, min_r};

    unique case (state_r)
      S_IDLE: begin
        // take a request
        if (start) begin
          cmd_nxt   = in_command;
          pool_nxt  = in_pool;
          id_nxt    = in_id_in;
          min_nxt   = in_min_id;
          max_nxt   = in_max_id;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        widx_nxt       = '0;
        out_id_nxt     = '0;
        out_status_nxt = ST_OK;
        if (max_r < min_r) begin
          count_nxt = '0;
        end else if (span > CNT_W'(MAX_IDS)) begin
          count_nxt = CNT_W'(MAX_IDS);
        end else begin
          count_nxt = span;
        end
        unique case (cmd_r)
          CMD_ALLOC: begin
            if (tag_unknown) begin
              out_status_nxt = ST_UNKNOWN;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else if (live_r[tag_idx]) begin
              state_nxt = S_SCAN_RD;
            end else begin
              state_nxt = S_FILL;
            end
          end
          CMD_RELEASE: begin
            if (tag_unknown || !live_r[tag_idx]) begin
              out_status_nxt = ST_UNKNOWN;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              state_nxt = S_REL_CHK;
            end
          end
          CMD_RESET_POOL: begin
            if (tag_unknown) begin
              out_status_nxt = ST_UNKNOWN;
            end else begin
              live_nxt[tag_idx] = 1'b0;
            end
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
          default: begin
            // unused command: answer ok, change nothing
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end

      S_FILL: begin
        // write one bitmap word; the first ID is taken right away
        word_we    = 1'b1;
        word_wdata = (widx_r == '0) ? (fill_word & ~WORD_W'(1)) : fill_word;
        rng_we     = widx_r == '0;
        if (last_word) begin
          live_nxt[tag_idx] = 1'b1;
          out_valid_nxt     = 1'b1;
          if (count_r != '0) begin
            out_id_nxt     = min_r;
            out_status_nxt = ST_OK;
          end else begin
            out_id_nxt     = '0;
            out_status_nxt = ST_EXHAUSTED;
          end
          state_nxt = S_IDLE;
        end else begin
          widx_nxt = widx_r + WIDX_W'(1);
        end
      end

      S_SCAN_RD: begin
        state_nxt = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        // take the lowest free bit, else advance to the next word
        if (word_rdata != '0) begin
          word_we        = 1'b1;
          word_wdata     = word_rdata & ~scan_iso;
          out_id_nxt     = alloc_id;
          out_status_nxt = ST_OK;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (last_word) begin
          out_id_nxt     = '0;
          out_status_nxt = ST_EXHAUSTED;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          widx_nxt  = widx_r + WIDX_W'(1);
          state_nxt = S_SCAN_RD;
        end
      end

      S_REL_CHK: begin
        // check the ID against the pool range
        if (id_r < rng_low || id_r > rng_high ||
            CNT_W'(rel_off) >= CNT_W'(MAX_IDS)) begin
          out_status_nxt = ST_RANGE;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          widx_nxt  = WIDX_W'(rel_off >> BIT_W);
          bit_nxt   = rel_off[BIT_W-1:0];
          state_nxt = S_REL_RD;
        end
      end

      S_REL_RD: begin
        state_nxt = S_REL_UPD;
      end

      S_REL_UPD: begin
        // set the bit unless it is already free
        if (word_rdata[bit_r]) begin
          out_status_nxt = ST_ALREADY_FREE;
        end else begin
          word_we    = 1'b1;
          word_wdata = word_rdata | (WORD_W'(1) << bit_r);
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, request and registered outputs
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    pool_r       <= pool_nxt;
    id_r         <= id_nxt;
    min_r        <= min_nxt;
    max_r        <= max_nxt;
    widx_r       <= widx_nxt;
    bit_r        <= bit_nxt;
    count_r      <= count_nxt;
    out_id_r     <= out_id_nxt;
    out_status_r <= out_status_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Free bitmaps, W words per pool
  lfid_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WDEPTH)
  ) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_addr),
    .wdata (word_wdata),
    .raddr (word_addr),
    .rdata (word_rdata)
  );

  // Pool ranges, {high, low}
  lfid_ram #(
    .WIDTH (2 * ID_WIDTH),
    .DEPTH (NUM_POOLS)
  ) u_range_ram (
    .clk   (clk),
    .we    (rng_we),
    .waddr (tag_idx),
    .wdata (rng_wdata),
    .raddr (tag_idx),
    .rdata (rng_rdata)
  );

  assign busy       = state_r != S_IDLE;
  assign out_valid  = out_valid_r;
  assign out_id_out = out_id_r;
  assign out_status = out_status_r;

endmodule

### hdl/lfid_chk.sv
// ----------------------------------------------------------------------------
// lfid_chk
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "lowest_free_id_pool_allocator_assert.svh"

module lfid_chk #(
  parameter int ID_WIDTH = lfid_pkg::ID_WIDTH_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [ID_WIDTH-1:0] out_id_out,
  input lfid_pkg::status_t   out_status
);

  import lfid_pkg::*;

  // A taken request makes the block busy in the next cycle
  `LFID_ASSERT_NXT(a_accept_busy, start && !busy, busy, "request accepted but not busy")

  // A result comes only when the block has finished
  `LFID_ASSERT_IMP(a_result_idle, out_valid, !busy, "result while busy")

  // A result strobe never repeats back to back
  `LFID_ASSERT_NXT(a_single_strobe, out_valid, !out_valid, "result strobe repeated")

  // Finishing a request always shows its result
  `LFID_ASSERT_IMP(a_done_result, $fell(busy) && $past(rst_n), out_valid, "request lost")

  // Failed requests carry no ID
  `LFID_ASSERT_IMP(a_fail_zero, out_valid && out_status != ST_OK, out_id_out == '0,
                   "nonzero ID on failed request")

endmodule

bind lowest_free_id_pool_allocator lfid_chk #(
  .ID_WIDTH (ID_WIDTH)
) u_lfid_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_id_out (out_id_out),
  .out_status (out_status)
);

### bench/lfid_bench_pkg.sv
// ----------------------------------------------------------------------------
// lfid_bench_pkg
// Expected-result model and result checker for the ID pool allocator bench.
// ----------------------------------------------------------------------------
package lfid_bench_pkg;
  import lfid_pkg::*;

  localparam int POOLS    = NUM_POOLS_DEF;
  localparam int POOL_IDS = MAX_IDS_DEF;
  localparam int IDW      = ID_WIDTH_DEF;

  // Command code the block treats as a no-op
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [IDW-1:0] id;
    status_t        status;
  } id_result_t;

  class id_pool_scoreboard;
    bit                pool_live [POOLS];
    bit [IDW-1:0]      pool_low  [POOLS];
    bit [IDW-1:0]      pool_high [POOLS];
    bit [POOL_IDS-1:0] free_map  [POOLS];
    id_result_t        pending_results[$];
    int                mismatches;

    function new();
      for (int p = 0; p < POOLS; p++) begin
        pool_live[p] = 1'b0;
        pool_low[p]  = '0;
        pool_high[p] = '0;
        free_map[p]  = '0;
      end
      mismatches = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Apply one accepted request to the pool state and queue its answer
    function void note_request(logic [CMD_W-1:0] cmd, logic [TAG_W-1:0] tag,
                               logic [IDW-1:0] id, logic [IDW-1:0] lo,
                               logic [IDW-1:0] hi);
      id_result_t  r;
      int unsigned p;
      int unsigned count;
      int unsigned off;
      bit          found;
      r.id     = '0;
      r.status = ST_OK;
      p        = tag;
      if (cmd != CMD_UNUSED && p >= POOLS) begin
        r.status = ST_UNKNOWN;
      end else if (cmd == CMD_ALLOC) begin
        // Fill a pool on its first allocate, clamping the span
        if (!pool_live[p]) begin
          if (hi >= lo) begin
            count = int'(hi) - int'(lo) + 1;
            if (count > POOL_IDS) begin
              count = POOL_IDS;
            end
            pool_high[p] = IDW'(int'(lo) + count - 1);
          end else begin
            count        = 0;
            pool_high[p] = hi;
          end
          pool_low[p] = lo;
          free_map[p] = '0;
          for (int b = 0; b < count; b++) begin
            free_map[p][b] = 1'b1;
          end
          pool_live[p] = 1'b1;
        end
        // Take the lowest free ID
        found = 1'b0;
        for (int b = 0; b < POOL_IDS && !found; b++) begin
          if (free_map[p][b]) begin
            free_map[p][b] = 1'b0;
            r.id           = IDW'(int'(pool_low[p]) + b);
            found          = 1'b1;
          end
        end
        if (!found) begin
          r.status = ST_EXHAUSTED;
        end
      end else if (cmd == CMD_RELEASE) begin
        if (!pool_live[p]) begin
          r.status = ST_UNKNOWN;
        end else if (id < pool_low[p] || id > pool_high[p]) begin
          r.status = ST_RANGE;
        end else begin
          off = int'(id) - int'(pool_low[p]);
          if (off >= POOL_IDS) begin
            r.status = ST_RANGE;
          end else if (free_map[p][off]) begin
            r.status = ST_ALREADY_FREE;
          end else begin
            free_map[p][off] = 1'b1;
          end
        end
      end else if (cmd == CMD_RESET_POOL) begin
        pool_live[p] = 1'b0;
      end
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] ERROR: %s", $realtime, what);
      end
    endfunction

    // Compare one strobed result against the oldest pending answer
    function void check_result(logic [IDW-1:0] id, status_t st);
      id_result_t r;
      if (pending_results.size() == 0) begin
        report($sformatf("result id=%h status=%0d with no request pending", id, st));
      end else begin
        r = pending_results[0];
        pending_results.delete(0);
        if (id !== r.id || st !== r.status) begin
          report($sformatf("id_out exp %h got %h, status exp %0d got %0d",
                           r.id, id, r.status, st));
        end
      end
    endfunction
  endclass

endpackage

### bench/tb_lowest_free_id_pool_allocator.sv
// ----------------------------------------------------------------------------
// tb_lowest_free_id_pool_allocator
// Drives directed and random allocate, release and reset-pool requests with
// random idle gaps, predicts each answer and checks every strobed result.
// ----------------------------------------------------------------------------
module tb_lowest_free_id_pool_allocator;
  import lfid_pkg::*;
  import lfid_bench_pkg::*;

  localparam int RANDOM_REQUESTS = 1050;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [CMD_W-1:0] in_command = '0;
  logic [TAG_W-1:0] in_pool = '0;
  logic [IDW-1:0]   in_id_in = '0;
  logic [IDW-1:0]   in_min_id = '0;
  logic [IDW-1:0]   in_max_id = '0;
  logic             out_valid;
  logic [IDW-1:0]   out_id_out;
  status_t          out_status;

  int                n_accepted = 0;
  bit                no_gaps = 1'b0;
  id_pool_scoreboard sb = new();

  lowest_free_id_pool_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_command (in_command),
    .in_pool    (in_pool),
    .in_id_in   (in_id_in),
    .in_min_id  (in_min_id),
    .in_max_id  (in_max_id),
    .out_valid  (out_valid),
    .out_id_out (out_id_out),
    .out_status (out_status)
  );

  always #6 clk = ~clk;

  // Check results, then note accepted requests
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        sb.check_result(out_id_out, out_status);
      end
      if (start && !busy) begin
        sb.note_request(in_command, in_pool, in_id_in, in_min_id, in_max_id);
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // Present one request after a random gap and hold it until accepted
  task automatic issue(logic [CMD_W-1:0] cmd, logic [TAG_W-1:0] tag,
                       logic [IDW-1:0] id, logic [IDW-1:0] lo, logic [IDW-1:0] hi);
    int gap;
    int target;
    if ($urandom_range(0, 39) == 0) begin
      no_gaps = ~no_gaps;
    end
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    in_command <= cmd;
    in_pool    <= tag;
    in_id_in   <= id;
    in_min_id  <= lo;
    in_max_id  <= hi;
    target = n_accepted + 1;
    do @(negedge clk); while (n_accepted < target);
  endtask

  // Hold off requests until every answer has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_directed();
    // Release to a pool never filled, reset of an idle pool, unused code
    issue(CMD_RELEASE, 3'd0, 16'h0000, 16'h0000, 16'h0000);
    issue(CMD_RESET_POOL, 3'd1, 16'h0000, 16'h0000, 16'h0000);
    issue(CMD_UNUSED, 3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // Full 16-bit span clamps to the pool size
    issue(CMD_ALLOC, 3'd0, 16'h0000, 16'h0000, 16'hFFFF);
    issue(CMD_ALLOC, 3'd0, 16'h0000, 16'h0000, 16'h0000);
    issue(CMD_RELEASE, 3'd0, 16'h0000, 16'h0000, 16'h0000);
    issue(CMD_RELEASE, 3'd0, 16'h0000, 16'h0000, 16'h0000);
    issue(CMD_RELEASE, 3'd0, 16'h0100, 16'h0000, 16'h0000);
    issue(CMD_RELEASE, 3'd0, 16'hFFFF, 16'h0000, 16'h0000);
    issue(CMD_ALLOC, 3'd0, 16'h0000, 16'hFFFF, 16'hFFFF);
    // Empty range: pool goes live with nothing free
    issue(CMD_ALLOC, 3'd1, 16'h0000, 16'h000A, 16'h0005);
    issue(CMD_RELEASE, 3'd1, 16'h0007, 16'h0000, 16'h0000);
    issue(CMD_ALLOC, 3'd1, 16'h0000, 16'h0000, 16'hFFFF);
    // Single-ID pool at the top of the ID space, exhausted and returned
    issue(CMD_ALLOC, 3'd2, 16'h0000, 16'hFFFF, 16'hFFFF);
    issue(CMD_ALLOC, 3'd2, 16'h0000, 16'h0000, 16'h0000);
    issue(CMD_RELEASE, 3'd2, 16'hFFFF, 16'h0000, 16'h0000);
    issue(CMD_ALLOC, 3'd2, 16'h0000, 16'h0000, 16'h0000);
    // Exactly full-size pool on the last tag, release below its range
    issue(CMD_ALLOC, 3'd7, 16'h0000, 16'hFF00, 16'hFFFF);
    issue(CMD_RELEASE, 3'd7, 16'hFEFF, 16'h0000, 16'h0000);
    // Reset drops the range; next allocate refills from new bounds
    issue(CMD_RESET_POOL, 3'd0, 16'h0000, 16'h0000, 16'h0000);
    issue(CMD_ALLOC, 3'd0, 16'h0000, 16'h0005, 16'h0009);
    issue(CMD_RELEASE, 3'd0, 16'h0004, 16'h0000, 16'h0000);
    issue(CMD_RELEASE, 3'd0, 16'h000A, 16'h0000, 16'h0000);
    issue(CMD_RESET_POOL, 3'd2, 16'h0000, 16'h0000, 16'h0000);
    issue(CMD_ALLOC, 3'd3, 16'h0000, 16'h0000, 16'h0000);
  endtask

  // Random requests, weighted toward allocate and in-range release
  task automatic run_random();
    logic [CMD_W-1:0] cmd;
    logic [TAG_W-1:0] tag;
    logic [IDW-1:0]   id;
    logic [IDW-1:0]   lo;
    logic [IDW-1:0]   hi;
    int               pick;
    int               span;
    int               width;
    int               tmp;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS / 2) begin
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 52) begin
        cmd = CMD_ALLOC;
      end else if (pick < 88) begin
        cmd = CMD_RELEASE;
      end else if (pick < 97) begin
        cmd = CMD_RESET_POOL;
      end else begin
        cmd = CMD_UNUSED;
      end
      // Keep a few pools busy so they run deep and exhaust
      tag = ($urandom_range(0, 3) == 0) ? TAG_W'($urandom_range(0, 7))
                                        : TAG_W'($urandom_range(0, 2));
      lo   = IDW'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        span = $urandom_range(0, 24);
      end else if (pick < 80) begin
        span = $urandom_range(25, 300);
      end else begin
        span = -1;
      end
      if (span < 0) begin
        hi = IDW'($urandom);
      end else begin
        tmp = int'(lo) + span;
        hi  = (tmp > 16'hFFFF) ? 16'hFFFF : IDW'(tmp);
      end
      // Aim releases at the live range, just past both ends sometimes
      if (sb.pool_live[tag] && $urandom_range(0, 4) != 0) begin
        width = int'(sb.pool_high[tag]) - int'(sb.pool_low[tag]);
        if (width < 0) begin
          width = 0;
        end
        tmp = int'(sb.pool_low[tag]) - 1 + int'($urandom_range(0, width + 2));
        id  = IDW'(tmp);
      end else begin
        id = IDW'($urandom);
      end
      issue(cmd, tag, id, lo, hi);
    end
  endtask

  initial begin
    int waited;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    drain_results();
    run_random();
    start <= 1'b0;
    // Wait out the last answers, bounded
    waited = 0;
    while (sb.pending() != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d answers never arrived", sb.pending()));
    end
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
